// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the escape byte group encoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define EBGE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define EBGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/ebge_pkg.sv -----
// ----------------------------------------------------------------------------
// Escape byte group encoder package
// Constants, the group record type and the code byte function.
// ----------------------------------------------------------------------------
`default_nettype none

package ebge_pkg;

    localparam int GROUP_BYTES      = 7;
    localparam int GROUPS_PER_FRAME = 7;
    localparam int BEAT_W           = 3;
    localparam int POS_W            = 3;

    localparam logic [7:0] ESC_IN      = 8'h1A;
    localparam logic [7:0] ESC_OUT     = 8'hA1;
    localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
    localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(GROUP_BYTES);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(GROUP_BYTES - 1);
    localparam logic [7:0]        LAST_GRP  = 8'(GROUPS_PER_FRAME - 1);

    typedef logic [GROUP_BYTES-1:0][7:0] t_group_bytes;
    typedef logic [GROUP_BYTES-1:0]      t_marks;

    typedef struct packed {
        t_group_bytes bytes;
        t_marks       marks;
        logic         frame_end;
    } t_group;

    function automatic logic [7:0] make_code(input t_marks marks);
        logic [7:0] m;
        m = {1'b0, marks};
        return (m & LOW_NIBBLE) | ((m & HIGH_NIBBLE) << 1);
    endfunction

endpackage

`default_nettype wire

// ----- design/escape_byte_group_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// Escape byte group encoder
// Top level: front end, group queue and back end.
// ----------------------------------------------------------------------------
// Payload bytes arrive one per beat and are taken in groups of seven; a byte of
// 0x1A is sent as 0xA1 and its position is marked in a code byte. With its
// seventh byte a group is written into the queue, then into the back end's
// register, and leaves as eight beats, one per cycle when not stalled: the code
// byte, then the seven escaped bytes, the last beat flagged as group end and, on
// every seventh group, frame end. A steady stream takes seven input bytes per
// eight output beats. A two-group queue lets input run ahead of a stalled output.
`default_nettype none

module escape_byte_group_encoder_unit import ebge_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_group_end,
    output logic            o_frame_end
);

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_not_empty;
    t_group push_group;
    t_group head_group;

    ebge_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_group     (push_group)
    );

    ebge_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_group     (push_group),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_head      (head_group)
    );

    ebge_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_head        (head_group),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_group_end   (o_group_end),
        .o_frame_end   (o_frame_end)
    );

endmodule

`default_nettype wire

// ----- design/ebge_front.sv -----
// ----------------------------------------------------------------------------
// Escape byte group encoder front end
// Accepts payload bytes, escapes them and gathers groups of seven.
// ----------------------------------------------------------------------------
`default_nettype none

module ebge_front import ebge_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_group          o_group
);

    logic [7:0]       r_store [GROUP_BYTES-1];
    t_marks           r_marks;
    t_marks           n_marks;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_group_count;
    logic [7:0]       n_group_count;
    logic             accept;
    logic             is_esc;
    logic [7:0]       esc_byte;
    t_marks           marks_now;
    logic             last_byte;
    logic             last_group;

    assign last_byte  = (r_pos == LAST_POS);
    assign last_group = (r_group_count == LAST_GRP);
    assign o_stall    = last_byte && i_q_full;
    assign accept     = i_valid && !o_stall;
    assign is_esc     = (i_data_byte == ESC_IN);
    assign esc_byte   = is_esc ? ESC_OUT : i_data_byte;
    assign marks_now  = r_marks | (is_esc ? (t_marks'(1) << r_pos) : '0);
    assign o_push     = accept && last_byte;

    always_comb begin
        for (int k = 0; k < GROUP_BYTES - 1; k++) begin
            o_group.bytes[k] = r_store[k];
        end
        o_group.bytes[GROUP_BYTES-1] = esc_byte;
        o_group.marks                = marks_now;
        o_group.frame_end            = last_group;
    end

    always_comb begin
        n_pos         = r_pos;
        n_marks       = r_marks;
        n_group_count = r_group_count;
        if (accept) begin
            if (last_byte) begin
                n_pos         = '0;
                n_marks       = '0;
                n_group_count = last_group ? '0 : r_group_count + 8'd1;
            end else begin
                n_pos   = r_pos + POS_W'(1);
                n_marks = marks_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_marks       <= '0;
            r_group_count <= '0;
        end else begin
            r_pos         <= n_pos;
            r_marks       <= n_marks;
            r_group_count <= n_group_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !last_byte) begin
            r_store[r_pos] <= esc_byte;
        end
    end

endmodule

`default_nettype wire

// ----- design/ebge_queue.sv -----
// ----------------------------------------------------------------------------
// Escape byte group encoder queue
// Two-entry queue of finished groups between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ebge_queue import ebge_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_group    i_group,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_not_empty,
    output t_group    o_head
);

    t_group     r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full      = (r_count == 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_head      = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_group;
        end
    end

endmodule

`default_nettype wire

// ----- design/ebge_back.sv -----
// ----------------------------------------------------------------------------
// Escape byte group encoder back end
// Sends each group as a code byte followed by its seven payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ebge_back import ebge_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_not_empty,
    input  t_group    i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic [7:0] o_out_byte,
    output logic      o_group_end,
    output logic      o_frame_end
);

    t_group            r_grp;
    logic              r_busy;
    logic [BEAT_W-1:0] r_beat;
    logic              out_acc;
    logic              last_beat;
    logic [BEAT_W-1:0] byte_idx;

    assign last_beat   = (r_beat == LAST_BEAT);
    assign out_acc     = r_busy && !i_stall;
    assign o_pop       = i_q_not_empty && (!r_busy || (out_acc && last_beat));
    assign byte_idx    = r_beat - BEAT_W'(1);
    assign o_valid     = r_busy;
    assign o_out_byte  = (r_beat == '0) ? make_code(r_grp.marks) : r_grp.bytes[byte_idx];
    assign o_group_end = last_beat;
    assign o_frame_end = last_beat && r_grp.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_beat <= '0;
        end else if (out_acc) begin
            if (last_beat) begin
                r_busy <= 1'b0;
            end else begin
                r_beat <= r_beat + BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_head;
        end
    end

endmodule

`default_nettype wire

// ----- design/ebge_checker.sv -----
// ----------------------------------------------------------------------------
// Escape byte group encoder checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ebge_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic [7:0] i_data_byte,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_group_end,
    input wire logic       o_frame_end
);

    logic out_acc;

    assign out_acc = o_valid && !i_stall;

    `EBGE_ASSERT_SAME(a_frame_in_group, i_clk, i_rst_n, o_valid && o_frame_end, o_group_end)
    `EBGE_ASSERT_NEXT(a_code_after_end, i_clk, i_rst_n, out_acc && o_group_end, !o_valid || (!o_group_end && !o_out_byte[4]))
    `EBGE_ASSERT_SAME(a_idle_no_stall, i_clk, i_rst_n, !o_valid, !o_stall)
    `EBGE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_byte) && $stable(o_group_end) && $stable(o_frame_end))

endmodule

bind escape_byte_group_encoder_unit ebge_checker u_ebge_checker (.*);

`default_nettype wire
